// ===== hw/rtl/frs_pkg.sv =====
// Shared types, constants and modular-arithmetic helpers for the Fibonacci range-sum tree.
// Used by frs_mat, frs_dp, frs_ctrl and the top level; depends on nothing else.
package frs_pkg;

	localparam int LEAVES = 1024;
	localparam int POS_W  = $clog2(LEAVES);
	localparam int CNT_W  = POS_W + 1;
	// heap-numbered nodes of a tree over at most LEAVES positions stay below 2*LEAVES
	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = $clog2(NODES);
	localparam int VAL_W  = 30;
	localparam int STEP_W = $clog2(VAL_W);
	// traversal stack: a pull frame and a right sibling for each of POS_W levels, plus three
	localparam int STK_DEPTH = 2 * POS_W + 3;
	localparam int STK_AW    = $clog2(STK_DEPTH);

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [STK_AW:0]   sp_t;

	localparam val_t MODULUS = val_t'(1000000007);

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// one tree node: summed (F(a), F(a-1)) and pending tag (F(k+1), F(k))
	typedef struct packed {
		val_t su;
		val_t sl;
		val_t tn;
		val_t tc;
	} row_t;

	localparam row_t ROW_RESET = '{su: '0, sl: '0, tn: val_t'(1), tc: '0};

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR,
		DP_BEGIN,
		DP_POW_STEP,
		DP_SET_ADD,
		DP_READ,
		DP_LEAF_WR,
		DP_ACC_ADD,
		DP_APPLY_ADD,
		DP_APPLY_PUSH,
		DP_APPLY_WR,
		DP_TAKE_TAG,
		DP_NODE_WR,
		DP_PULL_L,
		DP_PULL_WR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		node_t  addr;
	} dp_cmd_t;

	typedef struct packed {
		logic mat_done;
		logic k_zero;
		logic tag_ident;
	} dp_stat_t;

	function automatic val_t add_mod(val_t a, val_t b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
		return s[VAL_W-1:0];
	endfunction

	function automatic val_t sub_mod(val_t a, val_t b);
		logic [VAL_W:0] s;
		if (a >= b) s = {1'b0, a} - {1'b0, b};
		else s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
		return s[VAL_W-1:0];
	endfunction

	// one step of MSB-first interleaved modular multiplication
	function automatic val_t mm_step(val_t acc, val_t a, logic bit_in);
		val_t t;
		t = add_mod(acc, acc);
		if (bit_in) t = add_mod(t, a);
		return t;
	endfunction

endpackage

// ===== hw/rtl/fibonacci_range_sum_tree_unit.sv =====
// Top level of the Fibonacci range-sum tree: controller plus datapath.
// Uses frs_pkg, frs_ctrl and frs_dp.
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  command   start / busy         action, range_low, range_high, amount
//  result    done (1-cycle strobe) fib_sum, range_error
//  config    cfg_we               cfg_wdata (element_count)
//
// After reset and after every cfg_we the node memory is swept back to its reset
// values, one node per cycle, NODES (2048) nodes in all, with busy high.
// Load and add first raise the Fibonacci matrix to amount in the shared 30-step
// serial multiply unit, one square-and-multiply step per bit up to the top set bit of amount.
// The tree walk then visits nodes: load and add pull each expanded node's sums back
// from its two children, a range add runs the multiply unit at each node it covers,
// and at each node whose pending tag has to be pushed, the unit runs once per child.
// A query costs only the walk; a bad range or position is answered by the range check.
// Results cannot be held off: done is high for exactly one cycle per result.
module fibonacci_range_sum_tree_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  frs_pkg::pos_t         range_low,
	input  frs_pkg::pos_t         range_high,
	input  frs_pkg::val_t         amount,
	input  logic                  cfg_we,
	input  frs_pkg::cnt_t         cfg_wdata,
	output logic                  done,
	output frs_pkg::val_t         fib_sum,
	output logic                  range_error
);

	frs_pkg::dp_cmd_t  cmd;
	frs_pkg::dp_stat_t stat;

	frs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.range_low   (range_low),
		.range_high  (range_high),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.range_error (range_error),
		.cmd         (cmd),
		.stat        (stat)
	);

	frs_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.amount  (amount),
		.stat    (stat),
		.fib_sum (fib_sum)
	);

endmodule

// ===== hw/rtl/frs_mat.sv =====
// Bit-serial 2x2 Fibonacci-matrix multiply unit: eight modular product lanes.
// Uses frs_pkg; instantiated by frs_dp.
module frs_mat (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  frs_pkg::val_t x,
	input  frs_pkg::val_t y,
	input  frs_pkg::val_t v1u,
	input  frs_pkg::val_t v1w,
	input  frs_pkg::val_t v2u,
	input  frs_pkg::val_t v2w,
	output logic          done,
	output frs_pkg::val_t o1u,
	output frs_pkg::val_t o1w,
	output frs_pkg::val_t o2u,
	output frs_pkg::val_t o2w
);

	localparam int LANES = 8;

	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	frs_pkg::step_t      cnt_q;
	frs_pkg::val_t       a_q   [LANES];
	frs_pkg::val_t       acc_q [LANES];
	frs_pkg::val_t       nxt   [LANES];
	logic [LANES-1:0]    lane_bit;
	frs_pkg::val_t       bx_q, by_q, bd_q;
	frs_pkg::val_t       o1u_q, o1w_q, o2u_q, o2w_q;

	// lanes: x*u, y*w, y*u, d*w for vector 1, then the same for vector 2
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			case (i)
				0, 4:    lane_bit[i] = bx_q[frs_pkg::VAL_W-1];
				3, 7:    lane_bit[i] = bd_q[frs_pkg::VAL_W-1];
				default: lane_bit[i] = by_q[frs_pkg::VAL_W-1];
			endcase
			nxt[i] = frs_pkg::mm_step(acc_q[i], a_q[i], lane_bit[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + frs_pkg::step_t'(1);
				if (cnt_q == frs_pkg::step_t'(frs_pkg::VAL_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q[0] <= v1u; a_q[1] <= v1w; a_q[2] <= v1u; a_q[3] <= v1w;
			a_q[4] <= v2u; a_q[5] <= v2w; a_q[6] <= v2u; a_q[7] <= v2w;
			for (int i = 0; i < LANES; i++) acc_q[i] <= '0;
			bx_q <= x;
			by_q <= y;
			bd_q <= frs_pkg::sub_mod(x, y);
		end else if (busy_q) begin
			for (int i = 0; i < LANES; i++) acc_q[i] <= nxt[i];
			bx_q <= {bx_q[frs_pkg::VAL_W-2:0], 1'b0};
			by_q <= {by_q[frs_pkg::VAL_W-2:0], 1'b0};
			bd_q <= {bd_q[frs_pkg::VAL_W-2:0], 1'b0};
		end
		if (fin_q) begin
			o1u_q <= frs_pkg::add_mod(acc_q[0], acc_q[1]);
			o1w_q <= frs_pkg::add_mod(acc_q[2], acc_q[3]);
			o2u_q <= frs_pkg::add_mod(acc_q[4], acc_q[5]);
			o2w_q <= frs_pkg::add_mod(acc_q[6], acc_q[7]);
		end
	end

	assign done = done_q;
	assign o1u  = o1u_q;
	assign o1w  = o1w_q;
	assign o2u  = o2u_q;
	assign o2w  = o2w_q;

endmodule

// ===== hw/rtl/frs_dp.sv =====
// Datapath: node memory, matrix unit, power registers, query accumulator.
// Uses frs_pkg and frs_mat; driven by frs_ctrl through dp_cmd_t / dp_stat_t.
module frs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  frs_pkg::dp_cmd_t  cmd,
	input  frs_pkg::val_t     amount,
	output frs_pkg::dp_stat_t stat,
	output frs_pkg::val_t     fib_sum
);

	frs_pkg::row_t mem_q [frs_pkg::NODES];
	frs_pkg::row_t rd_q;
	frs_pkg::row_t wd;
	logic          we;

	frs_pkg::val_t r1_q, r0_q, b1_q, b0_q, k_q;
	frs_pkg::val_t ax_q, ay_q, px_q, py_q;
	frs_pkg::val_t nu_q, nl_q, plu_q, pll_q;
	frs_pkg::val_t acc_q;
	logic          pow_mode_q;

	logic          mat_start;
	frs_pkg::val_t mx, my, m1u, m1w, m2u, m2w;
	logic          mat_done;
	frs_pkg::val_t o1u, o1w, o2u, o2w;

	always_comb begin
		we = 1'b1;
		wd = frs_pkg::ROW_RESET;
		case (cmd.op)
			frs_pkg::DP_CLR:      wd = frs_pkg::ROW_RESET;
			frs_pkg::DP_LEAF_WR:  wd = '{su: r0_q, sl: frs_pkg::sub_mod(r1_q, r0_q),
				tn: frs_pkg::val_t'(1), tc: '0};
			frs_pkg::DP_APPLY_WR: wd = '{su: o1u, sl: o1w, tn: o2u, tc: o2w};
			frs_pkg::DP_NODE_WR:  wd = '{su: nu_q, sl: nl_q, tn: frs_pkg::val_t'(1), tc: '0};
			frs_pkg::DP_PULL_WR:  wd = '{su: frs_pkg::add_mod(plu_q, rd_q.su),
				sl: frs_pkg::add_mod(pll_q, rd_q.sl), tn: frs_pkg::val_t'(1), tc: '0};
			default:              we = 1'b0;
		endcase
	end

	always_comb begin
		mat_start = 1'b1;
		mx  = b1_q;
		my  = b0_q;
		m1u = r1_q;
		m1w = r0_q;
		m2u = b1_q;
		m2w = b0_q;
		case (cmd.op)
			frs_pkg::DP_POW_STEP: ;
			frs_pkg::DP_APPLY_ADD, frs_pkg::DP_APPLY_PUSH: begin
				mx  = (cmd.op == frs_pkg::DP_APPLY_ADD) ? ax_q : px_q;
				my  = (cmd.op == frs_pkg::DP_APPLY_ADD) ? ay_q : py_q;
				m1u = rd_q.su;
				m1w = rd_q.sl;
				m2u = rd_q.tn;
				m2w = rd_q.tc;
			end
			default: mat_start = 1'b0;
		endcase
	end

	frs_mat u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mat_start),
		.x      (mx),
		.y      (my),
		.v1u    (m1u),
		.v1w    (m1w),
		.v2u    (m2u),
		.v2w    (m2w),
		.done   (mat_done),
		.o1u    (o1u),
		.o1w    (o1w),
		.o2u    (o2u),
		.o2w    (o2w)
	);

	always_ff @(posedge clk) begin
		if (we) mem_q[cmd.addr] <= wd;
		if (cmd.op == frs_pkg::DP_READ) rd_q <= mem_q[cmd.addr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			frs_pkg::DP_BEGIN: begin
				r1_q <= frs_pkg::val_t'(1);
				r0_q <= '0;
				b1_q <= frs_pkg::val_t'(1);
				b0_q <= frs_pkg::val_t'(1);
				k_q  <= amount;
			end
			frs_pkg::DP_SET_ADD: begin
				ax_q <= r1_q;
				ay_q <= r0_q;
			end
			frs_pkg::DP_TAKE_TAG: begin
				px_q <= rd_q.tn;
				py_q <= rd_q.tc;
				nu_q <= rd_q.su;
				nl_q <= rd_q.sl;
			end
			frs_pkg::DP_PULL_L: begin
				plu_q <= rd_q.su;
				pll_q <= rd_q.sl;
			end
			default: ;
		endcase
		// square-and-multiply step lands when the unit finishes
		if (mat_done && pow_mode_q) begin
			if (k_q[0]) begin
				r1_q <= o1u;
				r0_q <= o1w;
			end
			b1_q <= o2u;
			b0_q <= o2w;
			k_q  <= {1'b0, k_q[frs_pkg::VAL_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_mode_q <= 1'b0;
			acc_q      <= '0;
		end else begin
			if (cmd.op == frs_pkg::DP_POW_STEP) pow_mode_q <= 1'b1;
			else if (mat_start) pow_mode_q <= 1'b0;
			if (cmd.op == frs_pkg::DP_BEGIN) acc_q <= '0;
			else if (cmd.op == frs_pkg::DP_ACC_ADD) acc_q <= frs_pkg::add_mod(acc_q, rd_q.su);
		end
	end

	assign stat.mat_done  = mat_done;
	assign stat.k_zero    = (k_q == '0);
	assign stat.tag_ident = (rd_q.tn == frs_pkg::val_t'(1)) && (rd_q.tc == '0);
	assign fib_sum        = acc_q;

endmodule

// ===== hw/rtl/frs_ctrl.sv =====
// Controller: handshake, range checks, clearing sweep and the tree walk with its frame stack.
// Uses frs_pkg; issues dp_cmd_t to frs_dp and reads dp_stat_t back.
module frs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              action,
	input  frs_pkg::pos_t           range_low,
	input  frs_pkg::pos_t           range_high,
	input  logic                    cfg_we,
	input  frs_pkg::cnt_t           cfg_wdata,
	output logic                    done,
	output logic                    range_error,
	output frs_pkg::dp_cmd_t        cmd,
	input  frs_pkg::dp_stat_t       stat
);

	typedef struct packed {
		logic          pull;
		frs_pkg::node_t node;
		frs_pkg::pos_t lo;
		frs_pkg::pos_t hi;
	} frame_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_POW, ST_POW_WAIT, ST_SETUP, ST_POP, ST_VISIT,
		ST_COV_RD, ST_ACC, ST_ADD_GO, ST_ADD_WAIT, ST_ADD_WR, ST_NODE_RD, ST_TAG,
		ST_CH_RD, ST_CH_GO, ST_CH_WAIT, ST_CH_WR, ST_NODE_WR, ST_EXP_P, ST_EXP_R,
		ST_EXP_L, ST_PULL_RL, ST_PULL_SL, ST_PULL_RR, ST_PULL_WR
	} state_t;

	state_t          state_q;
	frs_pkg::cnt_t   cnt_q;
	frs_pkg::node_t  clr_q;
	logic [1:0]      act_q;
	frs_pkg::pos_t   xl_q, xh_q;
	frame_t          stk_q [frs_pkg::STK_DEPTH];
	frs_pkg::sp_t    sp_q;
	frame_t          cur_q;
	logic            side_q;
	logic            done_q, err_q;

	frs_pkg::cnt_t   n_used, n_m1;
	logic            bad;
	logic [frs_pkg::POS_W:0] mid_sum;
	frs_pkg::pos_t   mid;
	logic            covered, leaf, go_right, go_left;
	frs_pkg::node_t  left_a, right_a, child_a;
	frame_t          root, push_frame;
	logic            push_en;

	always_comb begin
		n_used = (cnt_q > frs_pkg::cnt_t'(frs_pkg::LEAVES)) ?
			frs_pkg::cnt_t'(frs_pkg::LEAVES) : cnt_q;
		n_m1 = n_used - frs_pkg::cnt_t'(1);
		if (act_q == frs_pkg::ACT_LOAD)
			bad = (n_used == '0) || ({1'b0, xl_q} >= n_used);
		else
			bad = (n_used == '0) || (xl_q > xh_q) || ({1'b0, xh_q} >= n_used);
		root = '{pull: 1'b0, node: frs_pkg::node_t'(1), lo: '0,
			hi: n_m1[frs_pkg::POS_W-1:0]};
		mid_sum  = {1'b0, cur_q.lo} + {1'b0, cur_q.hi};
		mid      = mid_sum[frs_pkg::POS_W:1];
		covered  = (xl_q <= cur_q.lo) && (cur_q.hi <= xh_q);
		leaf     = (cur_q.lo == cur_q.hi);
		go_right = (act_q == frs_pkg::ACT_LOAD) ? (xl_q > mid) : (xh_q > mid);
		go_left  = (xl_q <= mid);
		left_a   = {cur_q.node[frs_pkg::NODE_W-2:0], 1'b0};
		right_a  = {cur_q.node[frs_pkg::NODE_W-2:0], 1'b1};
		child_a  = side_q ? right_a : left_a;
	end

	always_comb begin
		cmd        = '{op: frs_pkg::DP_NOP, addr: cur_q.node};
		push_en    = 1'b0;
		push_frame = root;
		unique case (state_q)
			ST_CLEAR:    cmd = '{op: frs_pkg::DP_CLR, addr: clr_q};
			ST_IDLE:     if (start) cmd.op = frs_pkg::DP_BEGIN;
			ST_CHECK:    push_en = (act_q == frs_pkg::ACT_QUERY) && !bad;
			ST_POW:      if (!stat.k_zero) cmd.op = frs_pkg::DP_POW_STEP;
			ST_SETUP: begin
				cmd.op  = frs_pkg::DP_SET_ADD;
				push_en = 1'b1;
			end
			ST_VISIT:
				if (!cur_q.pull && act_q == frs_pkg::ACT_LOAD && leaf)
					cmd.op = frs_pkg::DP_LEAF_WR;
			ST_COV_RD, ST_NODE_RD: cmd.op = frs_pkg::DP_READ;
			ST_ACC:      cmd.op = frs_pkg::DP_ACC_ADD;
			ST_ADD_GO:   cmd.op = frs_pkg::DP_APPLY_ADD;
			ST_ADD_WR:   cmd.op = frs_pkg::DP_APPLY_WR;
			ST_TAG:      cmd.op = frs_pkg::DP_TAKE_TAG;
			ST_CH_RD:    cmd = '{op: frs_pkg::DP_READ, addr: child_a};
			ST_CH_GO:    cmd.op = frs_pkg::DP_APPLY_PUSH;
			ST_CH_WR:    cmd = '{op: frs_pkg::DP_APPLY_WR, addr: child_a};
			ST_NODE_WR:  cmd.op = frs_pkg::DP_NODE_WR;
			ST_EXP_P: begin
				push_en    = (act_q != frs_pkg::ACT_QUERY);
				push_frame = '{pull: 1'b1, node: cur_q.node, lo: cur_q.lo, hi: cur_q.hi};
			end
			ST_EXP_R: begin
				push_en    = go_right;
				push_frame = '{pull: 1'b0, node: right_a,
					lo: mid + frs_pkg::pos_t'(1), hi: cur_q.hi};
			end
			ST_EXP_L: begin
				push_en    = go_left;
				push_frame = '{pull: 1'b0, node: left_a, lo: cur_q.lo, hi: mid};
			end
			ST_PULL_RL:  cmd = '{op: frs_pkg::DP_READ, addr: left_a};
			ST_PULL_SL:  cmd.op = frs_pkg::DP_PULL_L;
			ST_PULL_RR:  cmd = '{op: frs_pkg::DP_READ, addr: right_a};
			ST_PULL_WR:  cmd.op = frs_pkg::DP_PULL_WR;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en) stk_q[sp_q[frs_pkg::STK_AW-1:0]] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= frs_pkg::cnt_t'(frs_pkg::LEAVES);
			clr_q   <= '0;
			act_q   <= frs_pkg::ACT_NONE;
			xl_q    <= '0;
			xh_q    <= '0;
			sp_q    <= '0;
			cur_q   <= '0;
			side_q  <= 1'b0;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			err_q  <= 1'b0;
			if (push_en) sp_q <= sp_q + frs_pkg::sp_t'(1);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + frs_pkg::node_t'(1);
					if (clr_q == frs_pkg::node_t'(frs_pkg::NODES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE:
					if (start) begin
						act_q   <= action;
						xl_q    <= range_low;
						xh_q    <= range_high;
						sp_q    <= '0;
						state_q <= ST_CHECK;
					end
				ST_CHECK:
					if (act_q == frs_pkg::ACT_NONE) state_q <= ST_IDLE;
					else if (bad) begin
						done_q  <= 1'b1;
						err_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else if (act_q == frs_pkg::ACT_QUERY) state_q <= ST_POP;
					else state_q <= ST_POW;
				ST_POW:      state_q <= stat.k_zero ? ST_SETUP : ST_POW_WAIT;
				ST_POW_WAIT: if (stat.mat_done) state_q <= ST_POW;
				ST_SETUP:    state_q <= ST_POP;
				ST_POP:
					if (sp_q == '0) begin
						done_q  <= (act_q == frs_pkg::ACT_QUERY);
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= stk_q[sp_q[frs_pkg::STK_AW-1:0] - 1'b1];
						sp_q    <= sp_q - frs_pkg::sp_t'(1);
						state_q <= ST_VISIT;
					end
				ST_VISIT:
					if (cur_q.pull) state_q <= ST_PULL_RL;
					else if (act_q == frs_pkg::ACT_LOAD) state_q <= leaf ? ST_POP : ST_NODE_RD;
					else state_q <= covered ? ST_COV_RD : ST_NODE_RD;
				ST_COV_RD:   state_q <= (act_q == frs_pkg::ACT_QUERY) ? ST_ACC : ST_ADD_GO;
				ST_ACC:      state_q <= ST_POP;
				ST_ADD_GO:   state_q <= ST_ADD_WAIT;
				ST_ADD_WAIT: if (stat.mat_done) state_q <= ST_ADD_WR;
				ST_ADD_WR:   state_q <= ST_POP;
				ST_NODE_RD:  state_q <= ST_TAG;
				ST_TAG: begin
					// an identity tag leaves the children as they are
					side_q  <= 1'b0;
					state_q <= stat.tag_ident ? ST_EXP_P : ST_CH_RD;
				end
				ST_CH_RD:    state_q <= ST_CH_GO;
				ST_CH_GO:    state_q <= ST_CH_WAIT;
				ST_CH_WAIT:  if (stat.mat_done) state_q <= ST_CH_WR;
				ST_CH_WR:
					if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= ST_CH_RD;
					end else state_q <= ST_NODE_WR;
				ST_NODE_WR:  state_q <= ST_EXP_P;
				ST_EXP_P:    state_q <= ST_EXP_R;
				ST_EXP_R:    state_q <= ST_EXP_L;
				ST_EXP_L:    state_q <= ST_POP;
				ST_PULL_RL:  state_q <= ST_PULL_SL;
				ST_PULL_SL:  state_q <= ST_PULL_RR;
				ST_PULL_RR:  state_q <= ST_PULL_WR;
				ST_PULL_WR:  state_q <= ST_POP;
				default:     state_q <= ST_CLEAR;
			endcase
			// a register write restarts the clearing sweep
			if (cfg_we) begin
				cnt_q   <= cfg_wdata;
				clr_q   <= '0;
				sp_q    <= '0;
				done_q  <= 1'b0;
				err_q   <= 1'b0;
				state_q <= ST_CLEAR;
			end
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign range_error = err_q;

endmodule

// ===== hw/rtl/frs_chk.sv =====
// Port-level checker for fibonacci_range_sum_tree_unit, attached by bind.
// Uses frs_pkg for the field widths.
module frs_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          cfg_we,
	input logic          done,
	input frs_pkg::val_t fib_sum,
	input logic          range_error
);

	// busy only rises after an accepted item or a register write
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) || $past(cfg_we)))
		else $error("busy rose without an item or register write");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		range_error |-> (done && fib_sum == '0))
		else $error("error flag outside a zero-sum result");

endmodule

bind fibonacci_range_sum_tree_unit frs_chk u_frs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.cfg_we      (cfg_we),
	.done        (done),
	.fib_sum     (fib_sum),
	.range_error (range_error)
);
